// ----- sv/dwvb_pkg.sv -----
// ----------------------------------------------------------------------------
// dwvb_pkg
// Shared types and constants for the decaying wavetable voice bank.
// ----------------------------------------------------------------------------
package dwvb_pkg;

  localparam int MAX_VOICES_DEF    = 16;
  localparam int TABLE_ENTRIES_DEF = 1024;

  localparam logic [23:0] STEP_RESET = 24'd357914;
  localparam logic [23:0] AMP_LOUD   = 24'd209715;  // 0.05 in Q2.22
  localparam logic [23:0] AMP_QUIET  = 24'd420;     // 1e-4 in Q2.22
  localparam logic [25:0] INC_MAX    = 26'h3FFFFFF;

  // angles in Q30, used only while building the sine table
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_CHFREQ = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_PRUNE  = 3'd3,
    CMD_SAMPLE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // operation tagged onto a voice memory read
  typedef enum logic [2:0] {
    VOP_NONE   = 3'd0,
    VOP_ADD    = 3'd1,
    VOP_CHFREQ = 3'd2,
    VOP_PRUNE  = 3'd3,
    VOP_SAMPLE = 3'd4
  } vop_t;

  typedef struct packed {
    vop_t op;
    logic start;   // first read of a walk: clears accumulator and keep count
  } dp_ctrl_t;

  typedef struct packed {
    logic [25:0] inc;    // Q10.16
    logic [23:0] amp;    // Q2.22
    logic [25:0] phase;  // Q10.16
    logic [15:0] decay;  // Q0.16
  } voice_t;

endpackage

// ----- sv/dwvb_sine_rom.sv -----
// ----------------------------------------------------------------------------
// dwvb_sine_rom
// Sine lookup, Q1.15, one registered read per cycle. Contents are built at
// elaboration with a fixed-point Taylor series.
// ----------------------------------------------------------------------------
module dwvb_sine_rom #(
  parameter int TABLE_ENTRIES = dwvb_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] addr_i,
  output logic signed [15:0]               data_o
);

  typedef logic signed [15:0] rom_t [TABLE_ENTRIES];

  function automatic logic signed [15:0] sine_entry(input int i);
    longint a;
    longint x2;
    longint t;
    longint r;
    logic   neg;
    a = (longint'(i) * dwvb_pkg::TWO_PI_Q30 + longint'(TABLE_ENTRIES / 2)) / TABLE_ENTRIES;
    neg = 1'b0;
    if (a > dwvb_pkg::PI_Q30) begin
      a   = a - dwvb_pkg::PI_Q30;
      neg = 1'b1;
    end
    if (a > dwvb_pkg::HALF_PI_Q30) a = dwvb_pkg::PI_Q30 - a;
    if (a < 0) a = 0;
    x2 = (a * a) >>> 30;
    // Horner over the odd terms, 11th power down to 3rd
    t = dwvb_pkg::Q30_ONE;
    t = dwvb_pkg::Q30_ONE - ((x2 * t) >>> 30) / 110;
    if (t < 0) t = 0;
    t = dwvb_pkg::Q30_ONE - ((x2 * t) >>> 30) / 72;
    if (t < 0) t = 0;
    t = dwvb_pkg::Q30_ONE - ((x2 * t) >>> 30) / 42;
    if (t < 0) t = 0;
    t = dwvb_pkg::Q30_ONE - ((x2 * t) >>> 30) / 20;
    if (t < 0) t = 0;
    t = dwvb_pkg::Q30_ONE - ((x2 * t) >>> 30) / 6;
    if (t < 0) t = 0;
    r = (((a * t) >>> 30) + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return neg ? 16'(-r) : 16'(r);
  endfunction

  function automatic rom_t build_rom();
    rom_t tab;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tab[i] = sine_entry(i);
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    data_o <= SINE_ROM[addr_i];
  end

endmodule

// ----- sv/dwvb_voice_dp.sv -----
// ----------------------------------------------------------------------------
// dwvb_voice_dp
// Voice memory and its read-modify-write datapath: increment unit, sample
// pipeline (read, sine lookup, multiply, accumulate) and prune compaction.
// ----------------------------------------------------------------------------
module dwvb_voice_dp #(
  parameter int MAX_VOICES    = dwvb_pkg::MAX_VOICES_DEF,
  parameter int TABLE_ENTRIES = dwvb_pkg::TABLE_ENTRIES_DEF,
  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
  localparam int CW = $clog2(MAX_VOICES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dwvb_pkg::dp_ctrl_t  ctrl_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [23:0]         step_i,
  input  logic [19:0]         freq_i,
  input  logic [23:0]         amp_i,
  input  logic [15:0]         decay_i,
  output logic [CW-1:0]       keep_cnt_o,
  output logic signed [23:0]  sample_o
);

  localparam int RAW   = $clog2(TABLE_ENTRIES);
  localparam int ACC_W = 41 + $clog2(MAX_VOICES + 1);
  localparam logic [13:0] TAB_N  = 14'(TABLE_ENTRIES);
  localparam logic [13:0] TAB_N2 = 14'(2 * TABLE_ENTRIES);

  // phase integer part is below 4 * TABLE_ENTRIES: two compare-subtracts
  function automatic logic [RAW-1:0] tab_index(input logic [9:0] p);
    logic [13:0] v;
    v = 14'(p);
    if (v >= TAB_N2) v = v - TAB_N2;
    if (v >= TAB_N) v = v - TAB_N;
    return RAW'(v);
  endfunction

  dwvb_pkg::voice_t mem [MAX_VOICES];
  dwvb_pkg::voice_t rd_q;

  dwvb_pkg::vop_t   op_s1_r;
  logic [AW-1:0]    addr_s1_r;

  logic [43:0]      prod_r;
  logic [44:0]      inc_rnd;
  logic [32:0]      inc_sh;
  logic [25:0]      inc_val;

  logic             loud;
  logic [19:0]      d10;
  logic [16:0]      factor;
  logic [RAW-1:0]   rom_addr;
  logic signed [15:0] rom_q;

  logic             s2_vld_r;
  logic [AW-1:0]    s2_addr_r;
  dwvb_pkg::voice_t s2_ent_r;
  logic [23:0]      s2_amp_r;
  logic [40:0]      s2_dprod_r;

  logic             s3_vld_r;
  logic signed [40:0] s3_sprod_r;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_sh;
  logic [CW-1:0]    keep_r;
  logic             keep;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  dwvb_pkg::voice_t wr_data;

  // increment = (freq * step + 2^11) >> 12, saturated
  always_ff @(posedge clk) begin
    prod_r <= freq_i * step_i;
  end

  assign inc_rnd = {1'b0, prod_r} + 45'd2048;
  assign inc_sh  = inc_rnd[44:12];
  assign inc_val = (inc_sh > 33'(dwvb_pkg::INC_MAX)) ? dwvb_pkg::INC_MAX : inc_sh[25:0];

  // memory: one read port, one write port
  always_ff @(posedge clk) begin
    rd_q <= mem[addr_i];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_s1_r <= dwvb_pkg::VOP_NONE;
    end else begin
      op_s1_r <= ctrl_i.op;
    end
    addr_s1_r <= addr_i;
  end

  // stage 1: decay factor and table address from the entry just read
  assign loud = rd_q.amp > dwvb_pkg::AMP_LOUD;
  assign d10  = 20'({rd_q.decay, 3'b000}) + 20'({rd_q.decay, 1'b0});

  always_comb begin
    if (loud) begin
      factor = (d10 >= 20'd65536) ? 17'd0 : 17'(20'd65536 - d10);
    end else begin
      factor = 17'd65536 - 17'(rd_q.decay);
    end
  end

  assign rom_addr = tab_index(rd_q.phase[25:16]);
  assign keep     = rd_q.amp >= dwvb_pkg::AMP_QUIET;

  dwvb_sine_rom #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_rom (
    .clk    (clk),
    .addr_i (rom_addr),
    .data_o (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= (op_s1_r == dwvb_pkg::VOP_SAMPLE);
      s3_vld_r <= s2_vld_r;
    end
    s2_addr_r       <= addr_s1_r;
    s2_amp_r        <= rd_q.amp;
    s2_dprod_r      <= rd_q.amp * factor;
    s2_ent_r.inc    <= rd_q.inc;
    s2_ent_r.amp    <= rd_q.amp;
    s2_ent_r.phase  <= rd_q.phase + rd_q.inc;  // wraps at 2^26
    s2_ent_r.decay  <= rd_q.decay;
    s3_sprod_r      <= $signed({1'b0, s2_amp_r}) * rom_q;
  end

  // accumulator and prune keep count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      keep_r <= '0;
    end else begin
      if (ctrl_i.start) begin
        acc_r <= '0;
      end else if (s3_vld_r) begin
        acc_r <= acc_r + ACC_W'(s3_sprod_r);
      end
      if (ctrl_i.start) begin
        keep_r <= '0;
      end else if (op_s1_r == dwvb_pkg::VOP_PRUNE && keep) begin
        keep_r <= keep_r + 1'b1;
      end
    end
  end

  // write port: sample write-back, else the stage 1 operation.
  // Prune writes at keep_r <= current entry, always behind the read pointer.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_s1_r;
    wr_data = rd_q;
    if (s2_vld_r) begin
      wr_en       = 1'b1;
      wr_addr     = s2_addr_r;
      wr_data     = s2_ent_r;
      wr_data.amp = s2_dprod_r[39:16];
    end else begin
      case (op_s1_r)
        dwvb_pkg::VOP_ADD: begin
          wr_en         = 1'b1;
          wr_data.inc   = inc_val;
          wr_data.amp   = amp_i;
          wr_data.phase = '0;
          wr_data.decay = decay_i;
        end
        dwvb_pkg::VOP_CHFREQ: begin
          wr_en       = 1'b1;
          wr_data.inc = inc_val;
        end
        dwvb_pkg::VOP_PRUNE: begin
          wr_en   = keep;
          wr_addr = keep_r[AW-1:0];
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // sum of Q3.37 products -> Q8.16, round half up, floor shift, saturate
  assign acc_rnd = acc_r + ACC_W'(64'sd1048576);
  assign acc_sh  = acc_rnd >>> 21;

  always_comb begin
    if (acc_sh > ACC_W'(64'sd8388607)) begin
      sample_o = 24'sh7FFFFF;
    end else if (acc_sh < ACC_W'(-64'sd8388608)) begin
      sample_o = -24'sh800000;
    end else begin
      sample_o = acc_sh[23:0];
    end
  end

  assign keep_cnt_o = keep_r;

endmodule

// ----- sv/decaying_wavetable_voice_bank_core.sv -----
// ----------------------------------------------------------------------------
// decaying_wavetable_voice_bank_core
// Polyphonic wavetable voice bank: add, retune, clear, prune, and sample
// commands over a voice table held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  in        in_valid/in_stall  cmd, note_index, frequency, start_amplitude,
//                               decay_rate
//  out       out_valid/out_stall sample, voice_count, status
//  cfg       cfg_wr_en          cfg_wr_data (step_per_hz)
//
//  One item at a time. Sample and prune walk the voice memory, one read per
//  cycle, then drain; with no voices they go straight to done. Add and change
//  frequency write once, then drain; clear and rejected commands skip both.
//  Reset clears the voice count and loads step_per_hz; no memory clearing.
//  A result waits in the output register while out_stall is high; the next
//  item is taken meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module decaying_wavetable_voice_bank_core #(
  parameter int MAX_VOICES    = dwvb_pkg::MAX_VOICES_DEF,
  parameter int TABLE_ENTRIES = dwvb_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic [3:0]         in_note_index,
  input  logic [19:0]        in_frequency,
  input  logic [23:0]        in_start_amplitude,
  input  logic [15:0]        in_decay_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_sample,
  output logic [4:0]         out_voice_count,
  output logic [1:0]         out_status,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data
);

  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [23:0]         step_r;
  dwvb_pkg::cmd_t      cmd_r;
  logic [3:0]          idx_r;
  logic [19:0]         freq_r;
  logic [23:0]         amp_r;
  logic [15:0]         decay_r;
  logic [AW-1:0]       n_r, n_nxt;
  logic [1:0]          drain_r, drain_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  dwvb_pkg::status_t   status_r, status_nxt;
  logic                load_out;

  logic                out_valid_r;
  logic signed [23:0]  out_sample_r;
  logic [4:0]          out_count_r;
  dwvb_pkg::status_t   out_status_r;

  dwvb_pkg::dp_ctrl_t  ctrl;
  logic [AW-1:0]       dp_addr;
  logic [CW-1:0]       keep_cnt;
  logic signed [23:0]  dp_sample;
  logic                in_take;
  logic                walk_last;
  logic                full;
  logic                bad_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign walk_last = (CW'(n_r) + 1'b1) == count_r;
  assign full      = count_r == CW'(MAX_VOICES);
  assign bad_idx   = 32'(idx_r) >= 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dwvb_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      step_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= dwvb_pkg::cmd_t'(in_cmd);
      idx_r   <= in_note_index;
      freq_r  <= in_frequency;
      amp_r   <= in_start_amplitude;
      decay_r <= in_decay_rate;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    drain_nxt  = drain_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    ctrl.op    = dwvb_pkg::VOP_NONE;
    ctrl.start = 1'b0;
    dp_addr    = n_r;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt  = S_ISSUE;
          n_nxt      = '0;
          status_nxt = dwvb_pkg::STAT_OK;
        end
      end
      S_ISSUE: begin
        drain_nxt = 2'd2;
        unique case (cmd_r) inside
          dwvb_pkg::CMD_ADD: begin
            if (full) begin
              status_nxt = dwvb_pkg::STAT_FULL;
              state_nxt  = S_DONE;
            end else begin
              ctrl.op   = dwvb_pkg::VOP_ADD;
              dp_addr   = count_r[AW-1:0];
              state_nxt = S_DRAIN;
            end
          end
          dwvb_pkg::CMD_CHFREQ: begin
            if (bad_idx) begin
              status_nxt = dwvb_pkg::STAT_RANGE;
              state_nxt  = S_DONE;
            end else begin
              ctrl.op   = dwvb_pkg::VOP_CHFREQ;
              dp_addr   = AW'(idx_r);
              state_nxt = S_DRAIN;
            end
          end
          dwvb_pkg::CMD_PRUNE, dwvb_pkg::CMD_SAMPLE: begin
            if (count_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              ctrl.op    = (cmd_r == dwvb_pkg::CMD_PRUNE) ? dwvb_pkg::VOP_PRUNE
                                                          : dwvb_pkg::VOP_SAMPLE;
              ctrl.start = (n_r == '0);
              if (walk_last) begin
                n_nxt     = '0;
                state_nxt = S_DRAIN;
              end else begin
                n_nxt = n_r + 1'b1;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DRAIN: begin
        // covers memory read, sine lookup, multiply, accumulate
        drain_nxt = drain_r - 1'b1;
        if (drain_r == 2'd0) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            dwvb_pkg::CMD_ADD: begin
              if (status_r == dwvb_pkg::STAT_OK) count_nxt = count_r + 1'b1;
            end
            dwvb_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            dwvb_pkg::CMD_PRUNE: begin
              if (count_r != '0) count_nxt = keep_cnt;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      drain_r     <= '0;
      count_r     <= '0;
      status_r    <= dwvb_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      drain_r  <= drain_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= (cmd_r == dwvb_pkg::CMD_SAMPLE && count_r != '0) ? dp_sample
                                                                       : 24'sd0;
      out_count_r  <= 5'(count_nxt);
      out_status_r <= status_r;
    end
  end

  dwvb_voice_dp #(
    .MAX_VOICES    (MAX_VOICES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (ctrl),
    .addr_i     (dp_addr),
    .step_i     (step_r),
    .freq_i     (freq_r),
    .amp_i      (amp_r),
    .decay_i    (decay_r),
    .keep_cnt_o (keep_cnt),
    .sample_o   (dp_sample)
  );

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_voice_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

// ----- tb/decaying_wavetable_voice_bank_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decaying_wavetable_voice_bank_core_tb
// Self-checking bench for the voice bank. A cycle-free model of the bank
// (voice table, sine lookup, decay and prune rules) predicts every result.
// Directed items hit the boundary cases, then random sessions build voice
// sets and run long sample streams. Both channels idle at random, and the
// step_per_hz register is reloaded between phases.
// ----------------------------------------------------------------------------
module decaying_wavetable_voice_bank_core_tb;

  localparam int VOICES        = dwvb_pkg::MAX_VOICES_DEF;
  localparam int LUT_SIZE      = dwvb_pkg::TABLE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS  = 950;
  localparam int SETTLE_CYCLES = 30;   // outlasts the longest walk

  typedef struct packed {
    logic signed [23:0] smp;
    logic [4:0]         cnt;
    dwvb_pkg::status_t  st;
  } bank_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_cmd = '0;
  logic [3:0]         in_note_index = '0;
  logic [19:0]        in_frequency = '0;
  logic [23:0]        in_start_amplitude = '0;
  logic [15:0]        in_decay_rate = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] out_sample;
  logic [4:0]         out_voice_count;
  logic [1:0]         out_status;
  logic               cfg_wr_en = 1'b0;
  logic [23:0]        cfg_wr_data = '0;

  // bank model state
  logic [23:0] step_reg = dwvb_pkg::STEP_RESET;
  logic [25:0] v_inc[VOICES];
  logic [23:0] v_amp[VOICES];
  logic [25:0] v_phase[VOICES];
  logic [15:0] v_decay[VOICES];
  int          voice_total = 0;
  int          sine_lut[LUT_SIZE];

  bank_result_t expected_results[$];

  bit calm = 1'b0;   // no idling on either side while set
  int error_count = 0;
  int results_checked = 0;
  int cmd_total = 0;
  int samples_done = 0;
  int prunes_done = 0;
  int full_hits = 0;
  int range_hits = 0;
  int step_writes = 0;

  decaying_wavetable_voice_bank_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_note_index      (in_note_index),
    .in_frequency       (in_frequency),
    .in_start_amplitude (in_start_amplitude),
    .in_decay_rate      (in_decay_rate),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample         (out_sample),
    .out_voice_count    (out_voice_count),
    .out_status         (out_status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // sin(2*pi*i/N) in Q1.15: Q30 angle folded into the first quadrant,
  // Taylor series to x^11 by Horner with truncation
  function automatic int sine_q15(int i);
    longint ang, sq, acc, r;
    bit neg;
    ang = (longint'(i) * dwvb_pkg::TWO_PI_Q30 + LUT_SIZE / 2) / LUT_SIZE;
    neg = 1'b0;
    if (ang > dwvb_pkg::PI_Q30) begin
      ang -= dwvb_pkg::PI_Q30;
      neg = 1'b1;
    end
    if (ang > dwvb_pkg::HALF_PI_Q30) ang = dwvb_pkg::PI_Q30 - ang;
    if (ang < 0) ang = 0;
    sq = (ang * ang) >>> 30;
    acc = dwvb_pkg::Q30_ONE;
    for (int k = 11; k >= 3; k -= 2) begin
      acc = dwvb_pkg::Q30_ONE - ((sq * acc) >>> 30) / (k * (k - 1));
      if (acc < 0) acc = 0;
    end
    r = (((ang * acc) >>> 30) + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return neg ? -int'(r) : int'(r);
  endfunction

  function automatic logic [25:0] freq_to_inc(logic [19:0] fr);
    longint unsigned p;
    p = (longint'(fr) * longint'(step_reg) + 2048) >> 12;
    return (p > dwvb_pkg::INC_MAX) ? dwvb_pkg::INC_MAX : p[25:0];
  endfunction

  function automatic int sine_q15_lookup(logic [9:0] pos);
    return sine_lut[pos];
  endfunction

  task automatic bank_apply(input logic [2:0] c, input logic [3:0] idx,
                            input logic [19:0] fr, input logic [23:0] amp,
                            input logic [15:0] dec, output bank_result_t r);
    int keep;
    longint acc_sum, fac, v;
    r.smp = '0;
    r.st  = dwvb_pkg::STAT_OK;
    case (c)
      dwvb_pkg::CMD_ADD: begin
        if (voice_total >= VOICES) begin
          r.st = dwvb_pkg::STAT_FULL;
          full_hits++;
        end else begin
          v_inc[voice_total]   = freq_to_inc(fr);
          v_amp[voice_total]   = amp;
          v_phase[voice_total] = '0;
          v_decay[voice_total] = dec;
          voice_total++;
        end
      end
      dwvb_pkg::CMD_CHFREQ: begin
        if (idx >= voice_total) begin
          r.st = dwvb_pkg::STAT_RANGE;
          range_hits++;
        end else begin
          v_inc[idx] = freq_to_inc(fr);
        end
      end
      dwvb_pkg::CMD_CLEAR: voice_total = 0;
      dwvb_pkg::CMD_PRUNE: begin
        keep = 0;
        for (int n = 0; n < voice_total; n++) begin
          if (v_amp[n] >= dwvb_pkg::AMP_QUIET) begin
            v_inc[keep]   = v_inc[n];
            v_amp[keep]   = v_amp[n];
            v_phase[keep] = v_phase[n];
            v_decay[keep] = v_decay[n];
            keep++;
          end
        end
        voice_total = keep;
        prunes_done++;
      end
      dwvb_pkg::CMD_SAMPLE: begin
        acc_sum = 0;
        for (int n = 0; n < voice_total; n++) begin
          acc_sum += longint'(v_amp[n]) * sine_q15_lookup(v_phase[n][25:16]);
          v_phase[n] = v_phase[n] + v_inc[n];
          if (v_amp[n] > dwvb_pkg::AMP_LOUD) begin
            fac = 65536 - 10 * longint'(v_decay[n]);
            if (fac < 0) fac = 0;
          end else begin
            fac = 65536 - longint'(v_decay[n]);
          end
          v_amp[n] = 24'((longint'(v_amp[n]) * fac) >>> 16);
        end
        v = (acc_sum + 1048576) >>> 21;   // round half up, floor shift
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        r.smp = v[23:0];
        samples_done++;
      end
      default: ;
    endcase
    r.cnt = voice_total[4:0];
  endtask

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  // sends one item; in_valid stays high on return so the next item can
  // follow back to back
  task automatic send_item(input logic [2:0] c, input logic [3:0] idx,
                           input logic [19:0] fr, input logic [23:0] amp,
                           input logic [15:0] dec);
    bank_result_t r;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= c;
    in_note_index      <= idx;
    in_frequency       <= fr;
    in_start_amplitude <= amp;
    in_decay_rate      <= dec;
    do @(posedge clk); while (in_stall);
    bank_apply(c, idx, fr, amp, dec, r);
    expected_results.push_back(r);
    if (c <= dwvb_pkg::CMD_SAMPLE) cmd_total++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_step_per_hz(input logic [23:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_reg = value;
    step_writes++;
  endtask

  function automatic logic [19:0] pick_freq();
    return ($urandom_range(1) == 0) ? 20'($urandom_range(320000)) : 20'($urandom);
  endfunction

  function automatic logic [23:0] pick_amp();
    int roll;
    roll = $urandom_range(9);
    if (roll < 4) return 24'($urandom);
    if (roll < 8) return 24'($urandom_range(24'h200000));
    return 24'($urandom_range(4000));
  endfunction

  function automatic logic [15:0] pick_decay();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return 16'($urandom_range(300));
    if (roll < 8) return 16'($urandom_range(8000));
    return 16'($urandom);
  endfunction

  task automatic test_edge_commands();
    send_item(dwvb_pkg::CMD_SAMPLE, 4'h0, 20'h0, 24'h0, 16'h0);        // empty bank
    send_item(dwvb_pkg::CMD_PRUNE, 4'h0, 20'h0, 24'h0, 16'h0);
    send_item(dwvb_pkg::CMD_CHFREQ, 4'h0, 20'hFFFFF, 24'h0, 16'h0);    // nothing to retune
    for (int c = int'(dwvb_pkg::CMD_SAMPLE) + 1; c < 8; c++)
      send_item(3'(c), 4'hF, 20'hFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_item(dwvb_pkg::CMD_ADD, 4'h0, 20'hFFFFF, 24'hFFFFFF, 16'h0000);
    send_item(dwvb_pkg::CMD_ADD, 4'hF, 20'h00000, 24'h000000, 16'hFFFF);
    send_item(dwvb_pkg::CMD_SAMPLE, 4'h0, 20'h0, 24'h0, 16'h0);
    send_item(dwvb_pkg::CMD_SAMPLE, 4'hF, 20'hFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_item(dwvb_pkg::CMD_CHFREQ, 4'h1, 20'h12345, 24'h0, 16'h0);
    send_item(dwvb_pkg::CMD_CHFREQ, 4'h2, 20'h54321, 24'h0, 16'h0);    // one past the end
    send_item(dwvb_pkg::CMD_PRUNE, 4'h0, 20'h0, 24'h0, 16'h0);         // silent voice goes
    send_item(dwvb_pkg::CMD_SAMPLE, 4'h0, 20'h0, 24'h0, 16'h0);
    send_item(dwvb_pkg::CMD_CLEAR, 4'h0, 20'h0, 24'h0, 16'h0);
  endtask

  task automatic test_table_full();
    logic [23:0] amp;
    logic [15:0] dec;
    for (int i = 0; i <= VOICES; i++) begin
      case (i)
        0: begin amp = dwvb_pkg::AMP_LOUD;      dec = 16'd6554; end  // slow decay
        1: begin amp = dwvb_pkg::AMP_LOUD + 1;  dec = 16'd6554; end  // factor floors
        2: begin amp = dwvb_pkg::AMP_QUIET;     dec = 16'd0;    end  // survives prune
        3: begin amp = dwvb_pkg::AMP_QUIET - 1; dec = 16'd0;    end  // pruned
        default: begin amp = pick_amp(); dec = pick_decay(); end
      endcase
      send_item(dwvb_pkg::CMD_ADD, 4'($urandom), pick_freq(), amp, dec);
    end
    repeat (3) send_item(dwvb_pkg::CMD_SAMPLE, 4'h0, 20'h0, 24'h0, 16'h0);
    send_item(dwvb_pkg::CMD_PRUNE, 4'h0, 20'h0, 24'h0, 16'h0);
    send_item(dwvb_pkg::CMD_SAMPLE, 4'h0, 20'h0, 24'h0, 16'h0);
    send_item(dwvb_pkg::CMD_CLEAR, 4'h0, 20'h0, 24'h0, 16'h0);
  endtask

  task automatic test_step_sweep();
    logic [23:0] settings[5];
    settings = '{24'd0, 24'hFFFFFF, 24'd1, 24'($urandom), dwvb_pkg::STEP_RESET};
    foreach (settings[s]) begin
      load_step_per_hz(settings[s]);
      send_item(dwvb_pkg::CMD_ADD, 4'h0, 20'hFFFFF, pick_amp(), pick_decay());
      send_item(dwvb_pkg::CMD_ADD, 4'h0, pick_freq(), pick_amp(), pick_decay());
      send_item(dwvb_pkg::CMD_ADD, 4'h0, 20'h00001, pick_amp(), pick_decay());
      repeat (3) send_item(dwvb_pkg::CMD_SAMPLE, 4'h0, 20'h0, 24'h0, 16'h0);
      send_item(dwvb_pkg::CMD_CHFREQ, 4'h0, 20'hFFFFF, 24'h0, 16'h0);
      send_item(dwvb_pkg::CMD_SAMPLE, 4'h0, 20'h0, 24'h0, 16'h0);
      send_item(dwvb_pkg::CMD_CLEAR, 4'h0, 20'h0, 24'h0, 16'h0);
    end
  endtask

  // sessions: clear, build a voice set, then a long stream of mostly samples
  task automatic test_random_sessions();
    int first, roll, steps, session;
    first = cmd_total;
    session = 0;
    while (cmd_total - first < RANDOM_ITEMS) begin
      if (session > 0 && $urandom_range(3) == 0) begin
        roll = $urandom_range(3);
        load_step_per_hz(roll == 0 ? 24'd0 : roll == 1 ? 24'hFFFFFF : 24'($urandom));
      end
      calm = (session == 2);
      send_item(dwvb_pkg::CMD_CLEAR, 4'($urandom), 20'($urandom), 24'($urandom),
                16'($urandom));
      repeat ($urandom_range(1, VOICES + 2))
        send_item(dwvb_pkg::CMD_ADD, 4'($urandom), pick_freq(), pick_amp(),
                  pick_decay());
      steps = calm ? 200 : $urandom_range(20, 120);
      repeat (steps) begin
        roll = $urandom_range(99);
        if (roll < 70)
          send_item(dwvb_pkg::CMD_SAMPLE, 4'($urandom), 20'($urandom), 24'($urandom),
                    16'($urandom));
        else if (roll < 77)
          send_item(dwvb_pkg::CMD_CHFREQ,
                    (voice_total > 0 && $urandom_range(4) != 0) ?
                      4'($urandom_range(voice_total - 1)) : 4'($urandom),
                    pick_freq(), 24'($urandom), 16'($urandom));
        else if (roll < 83)
          send_item(dwvb_pkg::CMD_PRUNE, 4'($urandom), 20'($urandom), 24'($urandom),
                    16'($urandom));
        else if (roll < 89)
          send_item(dwvb_pkg::CMD_ADD, 4'($urandom), pick_freq(), pick_amp(),
                    pick_decay());
        else if (roll < 91)
          send_item(dwvb_pkg::CMD_CLEAR, 4'($urandom), 20'($urandom), 24'($urandom),
                    16'($urandom));
        else
          send_item(3'($urandom), 4'($urandom), 20'($urandom), 24'($urandom),
                    16'($urandom));
      end
      session++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    bank_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result: sample %0d count %0d status %0d",
                             out_sample, out_voice_count, out_status));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_sample !== exp_r.smp || out_voice_count !== exp_r.cnt ||
            out_status !== exp_r.st)
          flag_error($sformatf({"result %0d: expected sample %0d count %0d status %0d,",
                                " got %0d %0d %0d"},
                               results_checked, $signed(exp_r.smp), exp_r.cnt, exp_r.st,
                               out_sample, out_voice_count, out_status));
      end
    end
  end

  initial begin
    for (int i = 0; i < LUT_SIZE; i++) sine_lut[i] = sine_q15(i);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_commands();
    test_table_full();
    test_step_sweep();
    test_random_sessions();
    wait_idle();
    $display("covered %0d commands: %0d samples, %0d prunes, %0d full-table adds,",
             cmd_total, samples_done, prunes_done, full_hits);
    $display("%0d bad-index retunes, step_per_hz loaded %0d times, %0d results checked",
             range_hits, step_writes, results_checked);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("ERROR: timeout, %0d results still expected", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
